@@ rtl/core/pcc_pkg.sv @@
`timescale 1ns / 1ps

package pcc_pkg;

    localparam int unsigned CfgWidth  = 10;
    localparam int unsigned AddrWidth = 4;
    localparam int unsigned DataWidth = 32;

    typedef logic [CfgWidth-1:0] cfg_word_t;

    typedef enum logic [1:0] {
        REG_PHASE_TICKS     = 2'd0,
        REG_HOLD_TICKS      = 2'd1,
        REG_MOTION_WAIT_MAX = 2'd2,
        REG_UNUSED          = 2'd3
    } reg_index_t;

    localparam cfg_word_t PhaseTicksReset    = 10'd100;
    localparam cfg_word_t HoldTicksReset     = 10'd500;
    localparam cfg_word_t MotionWaitMaxReset = 10'd600;

    typedef enum logic [3:0] {
        PH_REST    = 4'd0,
        PH_WAIT    = 4'd1,
        PH_YELLOW  = 4'd2,
        PH_CARRED  = 4'd3,
        PH_WALK    = 4'd4,
        PH_HOLD    = 4'd5,
        PH_WALKEND = 4'd6,
        PH_REDYEL  = 4'd7,
        PH_GREEN   = 4'd8
    } phase_t;

    typedef struct packed {
        logic car_red;
        logic car_yellow;
        logic car_green;
        logic walk_red;
        logic walk_green;
        logic request_lamp;
    } lamps_t;

    function automatic lamps_t lamp_pattern(input phase_t ph);
        lamps_t l;
        unique case (ph)
            PH_REST:    l = 6'b001100;
            PH_WAIT:    l = 6'b001101;
            PH_YELLOW:  l = 6'b010101;
            PH_CARRED:  l = 6'b100101;
            PH_WALK:    l = 6'b100011;
            PH_HOLD:    l = 6'b100010;
            PH_WALKEND: l = 6'b100100;
            PH_REDYEL:  l = 6'b110100;
            PH_GREEN:   l = 6'b001100;
            default:    l = 6'b001100;
        endcase
        return l;
    endfunction

endpackage

@@ rtl/core/pcc_if.sv @@
`timescale 1ns / 1ps

interface pcc_tick_if;
    logic valid;
    logic ready;
    logic button_level;
    logic motion_level;

    modport source (output valid, output button_level, output motion_level, input ready);
    modport sink (input valid, input button_level, input motion_level, output ready);
endinterface

interface pcc_lamp_if;
    logic valid;
    logic ready;
    logic car_red;
    logic car_yellow;
    logic car_green;
    logic walk_red;
    logic walk_green;
    logic request_lamp;

    modport source (
        output valid, output car_red, output car_yellow, output car_green,
        output walk_red, output walk_green, output request_lamp, input ready
    );
    modport sink (
        input valid, input car_red, input car_yellow, input car_green,
        input walk_red, input walk_green, input request_lamp, output ready
    );
endinterface

@@ rtl/core/pedestrian_crossing_controller_unit.sv @@
// Path: tick transfer, input register, result register, lamp transfer.
// Throughput: one tick per cycle while lamp_out takes results; the phase and tick
// counter update once per tick in the single stage between the two registers.
// Reset: rst_n is asynchronous, active low; phase returns to rest with cars green,
// tick counter to zero, registers to 100 / 500 / 600, both stages empty.
`timescale 1ns / 1ps

module pedestrian_crossing_controller_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pcc_pkg::AddrWidth-1:0]  paddr,
    input  logic [pcc_pkg::DataWidth-1:0]  pwdata,
    output logic [pcc_pkg::DataWidth-1:0]  prdata,
    output logic                           pready,
    pcc_tick_if.sink                       tick_in,
    pcc_lamp_if.source                     lamp_out
);
    import pcc_pkg::*;

    cfg_word_t  phase_ticks_reg;
    cfg_word_t  hold_ticks_reg;
    cfg_word_t  motion_wait_max_reg;
    reg_index_t cfg_index;
    logic       cfg_write;

    logic   s1_valid_reg;
    logic   button_reg;
    logic   motion_reg;
    logic   out_valid_reg;
    lamps_t lamps_reg;
    lamps_t lamps_next;

    phase_t    phase_reg;
    phase_t    phase_next;
    cfg_word_t tick_count_reg;
    cfg_word_t tick_count_next;
    cfg_word_t phase_len;
    cfg_word_t len_raw;

    logic advance;
    logic step;

    assign pready    = 1'b1;
    assign cfg_index = reg_index_t'(paddr[AddrWidth-1:2]);
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg     <= PhaseTicksReset;
            hold_ticks_reg      <= HoldTicksReset;
            motion_wait_max_reg <= MotionWaitMaxReset;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PHASE_TICKS:     phase_ticks_reg     <= pwdata[CfgWidth-1:0];
                REG_HOLD_TICKS:      hold_ticks_reg      <= pwdata[CfgWidth-1:0];
                REG_MOTION_WAIT_MAX: motion_wait_max_reg <= pwdata[CfgWidth-1:0];
                REG_UNUSED:          ;
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_PHASE_TICKS:     prdata = {{(DataWidth-CfgWidth){1'b0}}, phase_ticks_reg};
            REG_HOLD_TICKS:      prdata = {{(DataWidth-CfgWidth){1'b0}}, hold_ticks_reg};
            REG_MOTION_WAIT_MAX: prdata = {{(DataWidth-CfgWidth){1'b0}}, motion_wait_max_reg};
            default:             prdata = '0;
        endcase
    end

    // Handshake: the result register parts the data, but ready passes straight through.
    assign advance       = !out_valid_reg || lamp_out.ready;
    assign tick_in.ready = !s1_valid_reg || advance;
    assign step          = s1_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (tick_in.ready)
        begin
            s1_valid_reg <= tick_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_in.ready && tick_in.valid)
        begin
            button_reg <= tick_in.button_level;
            motion_reg <= tick_in.motion_level;
        end
    end

    assign len_raw   = (phase_reg == PH_HOLD) ? hold_ticks_reg : phase_ticks_reg;
    assign phase_len = (len_raw == '0) ? cfg_word_t'(1) : len_raw;

    always_comb
    begin
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        unique case (phase_reg)
            PH_REST:
            begin
                if (button_reg)
                begin
                    if (motion_reg && (motion_wait_max_reg != '0))
                        phase_next = PH_WAIT;
                    else
                        phase_next = PH_YELLOW;
                    tick_count_next = cfg_word_t'(1);
                end
            end
            PH_WAIT:
            begin
                if (motion_reg && (tick_count_reg < motion_wait_max_reg))
                begin
                    tick_count_next = tick_count_reg + cfg_word_t'(1);
                end
                else
                begin
                    phase_next      = PH_YELLOW;
                    tick_count_next = cfg_word_t'(1);
                end
            end
            PH_YELLOW, PH_CARRED, PH_WALK, PH_HOLD, PH_WALKEND, PH_REDYEL, PH_GREEN:
            begin
                if (tick_count_reg >= phase_len)
                begin
                    if (phase_reg == PH_GREEN)
                    begin
                        phase_next      = PH_REST;
                        tick_count_next = '0;
                    end
                    else
                    begin
                        phase_next      = phase_t'(phase_reg + 4'd1);
                        tick_count_next = cfg_word_t'(1);
                    end
                end
                else
                begin
                    tick_count_next = tick_count_reg + cfg_word_t'(1);
                end
            end
            default:
            begin
                phase_next      = PH_REST;
                tick_count_next = '0;
            end
        endcase
    end

    always_comb
    begin
        lamps_next = lamp_pattern(phase_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_REST;
            tick_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                phase_reg      <= phase_next;
                tick_count_reg <= tick_count_next;
            end
            if (advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
            lamps_reg <= lamps_next;
    end

    assign lamp_out.valid        = out_valid_reg;
    assign lamp_out.car_red      = lamps_reg.car_red;
    assign lamp_out.car_yellow   = lamps_reg.car_yellow;
    assign lamp_out.car_green    = lamps_reg.car_green;
    assign lamp_out.walk_red     = lamps_reg.walk_red;
    assign lamp_out.walk_green   = lamps_reg.walk_green;
    assign lamp_out.request_lamp = lamps_reg.request_lamp;

    a_rest_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_REST) |-> (tick_count_reg == '0))
        else $error("tick counter not zero at rest");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_REST) |-> (tick_count_reg != '0))
        else $error("tick counter zero inside crossing sequence");

    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(phase_reg) && $stable(tick_count_reg))
        else $error("phase moved without a tick");

    a_walk_safe: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && lamps_reg.walk_green) |-> (lamps_reg.car_red && !lamps_reg.car_green))
        else $error("pedestrian green while cars not held at red");

    a_out_after_step: assert property (@(posedge clk) disable iff (!rst_n)
        (step) |=> out_valid_reg)
        else $error("processed tick produced no result");

endmodule
